@@ design/pip_pkg.sv @@
package pip_pkg;

   localparam int CoordWidth = 32;
   localparam int CountWidth = 7;
   localparam int MaxVertices = 64;
   localparam logic FuncLoad = 1'b0;
   localparam logic FuncQuery = 1'b1;
   localparam logic [0:0] RegVertexCount = 1'b0;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } div_req_type;

endpackage

@@ design/pip_if.sv @@
interface pip_req_if
   import pip_pkg::*;
;
   logic valid;
   logic ready;
   logic func;
   logic [5:0] vertex_slot;
   coord_type coord_x;
   coord_type coord_y;
   modport source (output valid, output func, output vertex_slot, output coord_x,
      output coord_y, input ready);
   modport sink (input valid, input func, input vertex_slot, input coord_x,
      input coord_y, output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   modport source (output valid, output inside_res, input ready);
   modport sink (input valid, input inside_res, output ready);
endinterface

@@ design/pip_ram.sv @@
module pip_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ design/pip_div.sv @@
module pip_div
   import pip_pkg::*;
(
   input logic clock,
   input logic reset,
   input div_req_type req,
   output logic busy,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [33:0] trial;

   assign trial = {rem_ff, quo_ff[63]} - {1'b0, den_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         den_in = req.divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = cnt_ff != 7'd0;
   assign quotient = quo_ff;
endmodule

@@ design/point_in_polygon_test.sv @@
// Crossing-number point-in-polygon test over a loaded vertex table.
// The req channel carries load and query items. A load transfer writes one
// vertex into the table and produces nothing. A query transfer produces one
// transfer on the rsp channel saying whether the point lies inside the
// polygon formed by the first vertex_count vertices, at most 64.
// The vertex_count register is written through the csr APB port at address 0.
// Loads can follow back to back while no result waits on rsp. A query
// reads the vertices one edge at a time; for each edge whose y-span
// straddles the query, the intercept goes through a 64-step radix-2
// divider. No new req is taken until the query has posted its result.
// A count of zero answers without reading the vertex table.
// Reset clears the control state and vertex_count; the vertex table is
// undefined until loaded. While the rsp receiver stalls, the result stays
// in its output register and the next req is taken only once it has gone.
module point_in_polygon_test
   import pip_pkg::*;
(
   input logic clock,
   input logic reset,
   pip_req_if.sink req,
   pip_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int AddrWidth = $clog2(MaxVertices);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StRead = 3'd1;
   localparam logic [2:0] StEdge = 3'd2;
   localparam logic [2:0] StDivWait = 3'd3;
   localparam logic [2:0] StDivDone = 3'd4;
   localparam logic [2:0] StResult = 3'd5;
   localparam logic [2:0] StNext = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] n_eff;
   logic [CountWidth-1:0] idx_ff, idx_in;
   logic first_ff, first_in;
   logic inside_ff, inside_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_bit_ff, rsp_bit_in;
   coord_type qx_ff, qx_in, qy_ff, qy_in;
   coord_type lx_ff, lx_in, ly_ff, ly_in;
   coord_type px_ff, px_in, py_ff, py_in;
   logic neg_ff, neg_in;
   logic [63:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;

   logic wr_en;
   logic [AddrWidth-1:0] rd_addr;
   coord_type rd_x, rd_y;
   div_req_type div_req;
   logic div_busy;
   logic [63:0] div_q;

   logic req_take;
   logic csr_write;
   logic signed [32:0] dx, dq, dy;
   logic [32:0] mdx, mdq, mdy;
   logic signed [34:0] icpt;
   logic [34:0] qext;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[1:0] == 2'd0) ? {25'd0, count_ff} : 32'd0;

   assign n_eff = (count_ff > CountWidth'(MaxVertices)) ? CountWidth'(MaxVertices)
      : count_ff;

   assign req.ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign req_take = req.valid && req.ready;
   assign wr_en = req_take && (req.func == FuncLoad)
      && ({1'b0, req.vertex_slot} < 7'(MaxVertices));

   pip_ram #(.Width(CoordWidth), .Depth(MaxVertices)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(AddrWidth'(req.vertex_slot)),
      .wr_data(req.coord_x), .rd_addr(rd_addr), .rd_data(rd_x));

   pip_ram #(.Width(CoordWidth), .Depth(MaxVertices)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(AddrWidth'(req.vertex_slot)),
      .wr_data(req.coord_y), .rd_addr(rd_addr), .rd_data(rd_y));

   pip_div u_div (.clock(clock), .reset(reset), .req(div_req), .busy(div_busy),
      .quotient(div_q));

   assign rd_addr = AddrWidth'(idx_ff);

   assign dx = 33'(lx_ff) - 33'(px_ff);
   assign dq = 33'(qy_ff) - 33'(py_ff);
   assign dy = 33'(ly_ff) - 33'(py_ff);
   assign mdx = dx[32] ? 33'(-dx) : 33'(dx);
   assign mdq = dq[32] ? 33'(-dq) : 33'(dq);
   assign mdy = dy[32] ? 33'(-dy) : 33'(dy);
   assign qext = div_q[34:0];
   assign icpt = neg_ff ? (35'(px_ff) - $signed(qext)) : (35'(px_ff) + $signed(qext));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      first_in = first_ff;
      inside_in = inside_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in = rsp_bit_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      lx_in = lx_ff;
      ly_in = ly_ff;
      px_in = px_ff;
      py_in = py_ff;
      neg_in = neg_ff;
      num_in = num_ff;
      den_in = den_ff;
      div_req.start = 1'b0;
      div_req.dividend = num_ff;
      div_req.divisor = den_ff;
      if (csr_write && csr_paddr[1:0] == {1'b0, RegVertexCount}) begin
         count_in = csr_pwdata[CountWidth-1:0];
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (req_take && req.func == FuncQuery) begin
               qx_in = req.coord_x;
               qy_in = req.coord_y;
               inside_in = 1'b0;
               if (n_eff == '0) begin
                  state_in = StResult;
               end else begin
                  idx_in = n_eff - CountWidth'(1);
                  first_in = 1'b1;
                  state_in = StRead;
               end
            end
         end
         StRead: begin
            state_in = StEdge;
         end
         StEdge: begin
            lx_in = px_ff;
            ly_in = py_ff;
            px_in = rd_x;
            py_in = rd_y;
            if (first_ff) begin
               first_in = 1'b0;
               idx_in = '0;
               state_in = StRead;
            end else begin
               state_in = StNext;
            end
         end
         StNext: begin
            if ((qy_ff < py_ff && qy_ff < ly_ff) || (qy_ff >= py_ff && qy_ff >= ly_ff)) begin
               state_in = StDivDone;
               num_in = '1;
            end else begin
               num_in = 64'(mdx) * 64'(mdq);
               den_in = mdy;
               neg_in = (dx[32] != dq[32]) != dy[32];
               state_in = StDivWait;
               div_req.start = 1'b1;
               div_req.dividend = 64'(mdx) * 64'(mdq);
               div_req.divisor = mdy;
            end
         end
         StDivWait: begin
            if (!div_busy) begin
               if (num_ff == '0) begin
                  neg_in = 1'b0;
               end
               state_in = StDivDone;
               num_in = '0;
            end
         end
         StDivDone: begin
            if (num_ff == '0 && !(35'(qx_ff) < icpt)) begin
               inside_in = !inside_ff;
            end
            if (idx_ff + CountWidth'(1) >= n_eff) begin
               state_in = StResult;
            end else begin
               idx_in = idx_ff + CountWidth'(1);
               state_in = StRead;
            end
         end
         StResult: begin
            rsp_valid_in = 1'b1;
            rsp_bit_in = inside_ff;
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      first_ff <= first_in;
      inside_ff <= inside_in;
      rsp_bit_ff <= rsp_bit_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      lx_ff <= lx_in;
      ly_ff <= ly_in;
      px_ff <= px_in;
      py_ff <= py_in;
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.inside_res = rsp_bit_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != StIdle |-> !req.ready)
      else $error("input taken while a query is in progress");
   a_div_only_wait: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == StDivWait)
      else $error("divider busy outside its wait state");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == StResult |=> rsp_valid_ff)
      else $error("result state did not raise rsp valid");
`endif
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb
   import pip_pkg::*;
();

   localparam int StallLimit = 50000;
   localparam int DrainCycles = 20;

   class inside_scoreboard;
      coord_type vert_x[MaxVertices];
      coord_type vert_y[MaxVertices];
      logic [CountWidth-1:0] active_count;
      bit inside_q[$];
      int errors;

      function new();
         active_count = '0;
         errors = 0;
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function longint edge_x_at(longint px, longint py, longint lx, longint ly,
         longint qy);
         longint dx, dq, dy;
         longint unsigned num, den, quot;
         bit neg;
         dx = lx - px;
         dq = qy - py;
         dy = ly - py;
         num = magnitude(dx) * magnitude(dq);
         den = magnitude(dy);
         quot = (den != 0) ? num / den : 0;
         neg = ((dx < 0) != (dq < 0)) != (dy < 0);
         if (num == 0) neg = 0;
         return neg ? px - longint'(quot) : px + longint'(quot);
      endfunction

      function bit point_inside(longint qx, longint qy);
         int n;
         longint px, py, lx, ly;
         bit c;
         n = active_count;
         c = 0;
         if (n > MaxVertices) n = MaxVertices;
         if (n == 0) return 0;
         px = vert_x[n-1];
         py = vert_y[n-1];
         for (int i = 0; i < n; i++) begin
            lx = px;
            ly = py;
            px = vert_x[i];
            py = vert_y[i];
            if (qy < py && qy < ly) continue;
            if (qy >= py && qy >= ly) continue;
            if (qx < edge_x_at(px, py, lx, ly, qy)) continue;
            c = !c;
         end
         return c;
      endfunction

      function void note_request(logic func, logic [5:0] slot, coord_type x, coord_type y);
         if (func == FuncLoad) begin
            vert_x[slot] = x;
            vert_y[slot] = y;
         end else begin
            inside_q.push_back(point_inside(x, y));
         end
      endfunction

      function void check_result(logic inside_res);
         bit exp_inside;
         if (inside_q.size() == 0) begin
            $error("unexpected result transfer, inside_res=%0b", inside_res);
            errors++;
            return;
         end
         exp_inside = inside_q.pop_front();
         if (inside_res !== exp_inside) begin
            $error("inside_res mismatch: expected %0b, actual %0b", exp_inside, inside_res);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   pip_req_if req ();
   pip_rsp_if rsp ();

   point_in_polygon_test dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   inside_scoreboard sb = new();
   bit idle_on = 1;
   int items_sent = 0;
   int quiet_cycles = 0;
   int rsp_stall = 0;
   coord_type range_lo = -100, range_hi = 100;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (rsp_stall > 0) begin
         rsp.ready <= 0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp.ready <= 1;
         if (idle_on && $urandom_range(0, 5) == 0) rsp_stall <= $urandom_range(1, 8);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            sb.note_request(req.func, req.vertex_slot, req.coord_x, req.coord_y);
         end
         if (rsp.valid && rsp.ready) begin
            sb.check_result(rsp.inside_res);
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (csr_psel && csr_penable)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send(logic func, logic [5:0] slot, coord_type x, coord_type y);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req.valid <= 1;
      req.func <= func;
      req.vertex_slot <= slot;
      req.coord_x <= x;
      req.coord_y <= y;
      do @(posedge clock); while (!req.ready);
      items_sent++;
   endtask

   task automatic go_idle();
      req.valid <= 0;
      @(posedge clock);
      while (sb.inside_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_count(logic [31:0] value);
      go_idle();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 2'(4 * RegVertexCount);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      sb.active_count = value[CountWidth-1:0];
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      if ($urandom_range(0, 4) == 0) return coord_type'($urandom());
      return coord_type'($urandom_range(0, range_hi - range_lo)) + range_lo;
   endfunction

   task automatic load_polygon(int n);
      for (int i = 0; i < n; i++) send(FuncLoad, 6'(i), rand_coord(), rand_coord());
   endtask

   task automatic query_some(int k);
      coord_type y;
      int n;
      n = (sb.active_count > MaxVertices) ? MaxVertices : sb.active_count;
      for (int j = 0; j < k; j++) begin
         y = rand_coord();
         if (n > 0 && $urandom_range(0, 2) == 0) y = sb.vert_y[$urandom_range(0, n - 1)];
         send(FuncQuery, 6'($urandom()), rand_coord(), y);
      end
   endtask

   initial begin
      int n, cnt;
      req.valid = 0;
      req.func = FuncLoad;
      req.vertex_slot = '0;
      req.coord_x = '0;
      req.coord_y = '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(FuncQuery, 6'h3f, 32'sh7fffffff, 32'sh80000000);
      send(FuncLoad, 6'd0, 0, 0);
      send(FuncLoad, 6'd1, 100, 0);
      send(FuncLoad, 6'd2, 0, 100);
      write_count(3);
      send(FuncQuery, 6'd0, 10, 10);
      send(FuncQuery, 6'd0, 200, 5);
      send(FuncQuery, 6'd0, 10, 0);
      send(FuncQuery, 6'd0, 0, 100);
      send(FuncQuery, 6'd0, -1, 50);
      send(FuncLoad, 6'd0, 32'sh80000000, 32'sh80000000);
      send(FuncLoad, 6'd1, 32'sh7fffffff, 32'sh80000000);
      send(FuncLoad, 6'd2, 32'sh7fffffff, 32'sh7fffffff);
      send(FuncQuery, 6'd0, 32'sh7fffffff, 0);
      send(FuncQuery, 6'd0, 32'sh80000000, 32'sh7ffffffe);
      send(FuncQuery, 6'd0, 0, 32'sh80000000);
      write_count(1);
      send(FuncQuery, 6'd0, 0, 0);
      write_count(2);
      send(FuncQuery, 6'd0, 0, 0);
      send(FuncQuery, 6'd0, 32'sh7fffffff, -5);

      range_lo = 32'sh80000000;
      range_hi = 32'sh7fffffff;
      write_count(0);
      load_polygon(MaxVertices);
      write_count(127);
      query_some(2);
      write_count(64);
      query_some(2);

      while (items_sent < 300) begin
         if (items_sent > 250) idle_on = 0;
         if ($urandom_range(0, 1) == 0) begin
            range_lo = -100;
            range_hi = 100;
         end else begin
            range_lo = 32'sh80000000;
            range_hi = 32'sh7fffffff;
         end
         case ($urandom_range(0, 9))
            0: cnt = 0;
            1: cnt = $urandom_range(1, 2);
            2: cnt = $urandom_range(13, 127);
            default: cnt = $urandom_range(3, 12);
         endcase
         n = (cnt > MaxVertices) ? MaxVertices : cnt;
         write_count(32'(cnt) | ($urandom() & 32'hffffff80));
         load_polygon(n);
         query_some($urandom_range(3, 8));
         if (n > 0 && $urandom_range(0, 2) == 0) begin
            send(FuncLoad, 6'($urandom_range(0, n - 1)), rand_coord(), rand_coord());
            query_some(2);
         end
      end

      go_idle();
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0 && sb.inside_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         if (sb.inside_q.size() != 0)
            $error("%0d expected results never arrived", sb.inside_q.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ point_in_polygon_test.f @@
design/pip_pkg.sv
design/pip_if.sv
design/pip_ram.sv
design/pip_div.sv
design/point_in_polygon_test.sv
tb/tb.sv
